// File: rtl/core/bdc_pkg.sv
package bdc_pkg;

	localparam int unsigned CntW   = 16;
	localparam int unsigned DigitW = 4;

	localparam logic [CntW-1:0]   IdleTicksRst   = CntW'(1000);
	localparam logic [CntW-1:0]   RepeatTicksRst = CntW'(100);
	localparam logic [CntW-1:0]   BlinkTicksRst  = CntW'(50);
	localparam logic [DigitW-1:0] DigitMax       = DigitW'(9);
	localparam logic [DigitW-1:0] DigitStart     = DigitW'(5);

	typedef enum logic [1:0] {
		REG_IDLE_TICKS   = 2'd0,
		REG_REPEAT_TICKS = 2'd1,
		REG_BLINK_TICKS  = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_INIT      = 3'd0,
		MODE_NORMAL    = 3'd1,
		MODE_RESET     = 3'd2,
		MODE_UP        = 3'd3,
		MODE_DOWN      = 3'd4,
		MODE_LONG_UP   = 3'd5,
		MODE_LONG_DOWN = 3'd6,
		MODE_IDLE      = 3'd7
	} mode_t;

	typedef struct packed {
		logic reset_press;
		logic up_press;
		logic down_press;
		logic reset_release;
		logic up_release;
		logic down_release;
		logic up_long_hold;
		logic down_long_hold;
	} events_t;

	typedef struct packed {
		mode_t             mode;
		logic [DigitW-1:0] digit;
		logic [CntW-1:0]   main_cnt;
		logic              main_exp;
		logic [CntW-1:0]   blink_cnt;
		logic              blink_exp;
		logic              led;
	} state_t;

	typedef struct packed {
		logic [CntW-1:0] idle_ticks;
		logic [CntW-1:0] repeat_ticks;
		logic [CntW-1:0] blink_ticks;
	} cfg_t;

	function automatic logic [CntW-1:0] load_val(input logic [CntW-1:0] v);
		return (v == '0) ? CntW'(1) : v;
	endfunction

	function automatic logic [DigitW-1:0] dig_up(input logic [DigitW-1:0] d);
		return (d >= DigitMax) ? '0 : d + DigitW'(1);
	endfunction

	function automatic logic [DigitW-1:0] dig_down(input logic [DigitW-1:0] d);
		return (d != '0) ? d - DigitW'(1) : DigitMax;
	endfunction

endpackage

// File: rtl/core/bdc_step.sv
module bdc_step
	import bdc_pkg::*;
(
	input  state_t  cur,
	input  events_t ev,
	input  cfg_t    cfg,
	output state_t  nxt
);

	always_comb begin
		state_t s;
		s = cur;

		// countdowns advance first
		if (s.main_cnt != '0) begin
			s.main_cnt = s.main_cnt - CntW'(1);
			if (s.main_cnt == '0)
				s.main_exp = 1'b1;
		end
		if (s.blink_cnt != '0) begin
			s.blink_cnt = s.blink_cnt - CntW'(1);
			if (s.blink_cnt == '0)
				s.blink_exp = 1'b1;
		end

		case (cur.mode)
			MODE_INIT: begin
				s.digit     = DigitStart;
				s.led       = 1'b1;
				s.main_cnt  = load_val(cfg.idle_ticks);
				s.main_exp  = 1'b0;
				s.blink_cnt = load_val(cfg.blink_ticks);
				s.blink_exp = 1'b0;
				s.mode      = MODE_NORMAL;
			end
			MODE_NORMAL: begin
				if (ev.reset_press) begin
					s.main_cnt = '0;
					s.main_exp = 1'b0;
					s.mode     = MODE_RESET;
				end
				if (ev.up_press) begin
					s.main_cnt = '0;
					s.main_exp = 1'b0;
					s.digit    = dig_up(s.digit);
					s.mode     = MODE_UP;
				end
				if (ev.down_press) begin
					s.main_cnt = '0;
					s.main_exp = 1'b0;
					s.digit    = dig_down(s.digit);
					s.mode     = MODE_DOWN;
				end
				if (s.main_exp) begin
					if (s.digit != '0)
						s.digit = s.digit - DigitW'(1);
					s.main_cnt = load_val(cfg.repeat_ticks);
					s.main_exp = 1'b0;
					s.mode     = MODE_IDLE;
				end
			end
			MODE_RESET: begin
				s.digit = '0;
				if (ev.reset_release) begin
					s.main_cnt = load_val(cfg.idle_ticks);
					s.main_exp = 1'b0;
					s.mode     = MODE_NORMAL;
				end
			end
			MODE_UP: begin
				if (ev.up_release) begin
					s.main_cnt = load_val(cfg.idle_ticks);
					s.main_exp = 1'b0;
					s.mode     = MODE_NORMAL;
				end
				if (ev.up_long_hold) begin
					s.digit    = dig_up(s.digit);
					s.main_cnt = load_val(cfg.repeat_ticks);
					s.main_exp = 1'b0;
					s.mode     = MODE_LONG_UP;
				end
			end
			MODE_DOWN: begin
				if (ev.down_release) begin
					s.main_cnt = load_val(cfg.idle_ticks);
					s.main_exp = 1'b0;
					s.mode     = MODE_NORMAL;
				end
				if (ev.down_long_hold) begin
					s.digit    = dig_down(s.digit);
					s.main_cnt = load_val(cfg.repeat_ticks);
					s.main_exp = 1'b0;
					s.mode     = MODE_LONG_DOWN;
				end
			end
			MODE_LONG_UP: begin
				if (s.main_exp) begin
					s.digit    = dig_up(s.digit);
					s.main_cnt = load_val(cfg.repeat_ticks);
					s.main_exp = 1'b0;
				end
				if (ev.up_release) begin
					s.main_cnt = load_val(cfg.idle_ticks);
					s.main_exp = 1'b0;
					s.mode     = MODE_NORMAL;
				end
			end
			MODE_LONG_DOWN: begin
				if (s.main_exp) begin
					s.digit    = dig_down(s.digit);
					s.main_cnt = load_val(cfg.repeat_ticks);
					s.main_exp = 1'b0;
				end
				if (ev.down_release) begin
					s.main_cnt = load_val(cfg.idle_ticks);
					s.main_exp = 1'b0;
					s.mode     = MODE_NORMAL;
				end
			end
			default: begin
				// idle countdown, stops at zero
				if (s.digit != '0) begin
					if (s.main_exp) begin
						s.digit    = s.digit - DigitW'(1);
						s.main_cnt = load_val(cfg.repeat_ticks);
						s.main_exp = 1'b0;
					end
				end else begin
					s.main_cnt = '0;
					s.main_exp = 1'b0;
				end
				if (ev.reset_press) begin
					s.main_cnt = '0;
					s.main_exp = 1'b0;
					s.mode     = MODE_RESET;
				end
				if (ev.up_press) begin
					s.main_cnt = '0;
					s.main_exp = 1'b0;
					s.digit    = dig_up(s.digit);
					s.mode     = MODE_UP;
				end
				if (ev.down_press) begin
					s.main_cnt = '0;
					s.main_exp = 1'b0;
					s.digit    = dig_down(s.digit);
					s.mode     = MODE_DOWN;
				end
			end
		endcase

		// blinker runs in every mode
		if (s.blink_exp) begin
			s.led       = ~s.led;
			s.blink_cnt = load_val(cfg.blink_ticks);
			s.blink_exp = 1'b0;
		end

		nxt = s;
	end

endmodule

// File: rtl/core/button_digit_counter_fsm.sv
// Button-driven 0..9 digit counter with idle countdown and red LED blinker.
// One input transaction is one timer tick carrying the button events; each
// tick gives one output transaction with digit, LED level and mode after it.
// A tick is held in an input register, then applied to the state and moved
// to the output register; a tick is taken every cycle unless out_ready
// stalls the full output register. The cfg port sets idle, repeat and blink
// periods in ticks (index 0, 1, 2; a zero value acts as one); it is always
// ready and a new value takes effect the next time a countdown is loaded.
module button_digit_counter_fsm
	import bdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [CntW-1:0]   cfg_data,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic              reset_press,
	input  logic              up_press,
	input  logic              down_press,
	input  logic              reset_release,
	input  logic              up_release,
	input  logic              down_release,
	input  logic              up_long_hold,
	input  logic              down_long_hold,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [DigitW-1:0] digit,
	output logic              led_red,
	output logic [2:0]        mode
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	events_t ev_s1;
	logic    valid_s1;
	logic    out_valid_q;
	logic    advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_ticks   <= IdleTicksRst;
			cfg_q.repeat_ticks <= RepeatTicksRst;
			cfg_q.blink_ticks  <= BlinkTicksRst;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_IDLE_TICKS:   cfg_q.idle_ticks   <= cfg_data;
				REG_REPEAT_TICKS: cfg_q.repeat_ticks <= cfg_data;
				REG_BLINK_TICKS:  cfg_q.blink_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ev_s1 <= '{reset_press:    reset_press,
			           up_press:       up_press,
			           down_press:     down_press,
			           reset_release:  reset_release,
			           up_release:     up_release,
			           down_release:   down_release,
			           up_long_hold:   up_long_hold,
			           down_long_hold: down_long_hold};
		end
	end

	bdc_step u_step (
		.cur (state_q),
		.ev  (ev_s1),
		.cfg (cfg_q),
		.nxt (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode      <= MODE_INIT;
			state_q.digit     <= '0;
			state_q.main_cnt  <= '0;
			state_q.main_exp  <= 1'b0;
			state_q.blink_cnt <= '0;
			state_q.blink_exp <= 1'b0;
			state_q.led       <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			digit   <= state_nxt.digit;
			led_red <= state_nxt.led;
			mode    <= 3'(state_nxt.mode);
		end
	end

endmodule
